[rtl/gfdmd_pkg.sv]
// shared types, codes and constants for the grid frame-difference motion detector
// no dependencies
package gfdmd_pkg;

    localparam int P_MAX_CELLS = 1024;

    localparam int DIV_NW = 33;
    localparam int DIV_DW = 20;

    localparam logic [19:0] CNT_MAX = 20'hFFFFF;

    localparam logic signed [23:0] C_RV   = 24'sd5743;
    localparam logic signed [23:0] C_GU   = 24'sd1411;
    localparam logic signed [23:0] C_GV   = 24'sd2925;
    localparam logic signed [23:0] C_BU   = 24'sd7258;
    localparam logic signed [23:0] C_HALF = 24'sd2048;

    localparam logic [2:0] MM_U     = 3'd0;
    localparam logic [2:0] MM_Y     = 3'd1;
    localparam logic [2:0] MM_V     = 3'd2;
    localparam logic [2:0] MM_RED   = 3'd3;
    localparam logic [2:0] MM_GREEN = 3'd4;
    localparam logic [2:0] MM_BLUE  = 3'd5;

    localparam logic [1:0] RM_ALL = 2'd0;
    localparam logic [1:0] RM_IN  = 2'd1;
    localparam logic [1:0] RM_OUT = 2'd2;

    localparam logic [2:0] CFG_MEASURE_MODE = 3'd0;
    localparam logic [2:0] CFG_THRESHOLD    = 3'd1;
    localparam logic [2:0] CFG_DELAY        = 3'd2;
    localparam logic [2:0] CFG_REGION_MODE  = 3'd3;
    localparam logic [2:0] CFG_COL_FIRST    = 3'd4;
    localparam logic [2:0] CFG_COL_LAST     = 3'd5;
    localparam logic [2:0] CFG_ROW_FIRST    = 3'd6;
    localparam logic [2:0] CFG_ROW_LAST     = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_FIN,
        ST_OUT,
        ST_STOP
    } t_state;

endpackage

[rtl/gfdmd_measure.sv]
// per-pixel measure: raw Y/U/V or fixed-point RGB clipped to 0..255
// depends on gfdmd_pkg
module gfdmd_measure (
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_luma,
    input  logic signed [7:0] i_u,
    input  logic signed [7:0] i_v,
    output logic signed [8:0] o_val
);
    import gfdmd_pkg::*;

    logic signed [23:0] y_s;
    logic signed [23:0] u_s;
    logic signed [23:0] v_s;
    logic signed [23:0] t_r;
    logic signed [23:0] t_g;
    logic signed [23:0] t_b;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    function automatic logic [7:0] clip(input logic signed [23:0] t);
        logic signed [11:0] s;
        s = 12'(t >>> 12);
        if (s < 0) begin
            clip = 8'd0;
        end else if (s > 12'sd255) begin
            clip = 8'd255;
        end else begin
            clip = s[7:0];
        end
    endfunction

    always_comb begin
        y_s = $signed({16'd0, i_luma}) <<< 12;
        u_s = 24'(i_u);
        v_s = 24'(i_v);
        t_r = y_s + v_s * C_RV + C_HALF;
        t_g = y_s - u_s * C_GU - v_s * C_GV + C_HALF;
        t_b = y_s + u_s * C_BU + C_HALF;
        red   = clip(t_r);
        green = clip(t_g);
        blue  = clip(t_b);
        case (i_mode)
            MM_U:     o_val = 9'(i_u);
            MM_V:     o_val = 9'(i_v);
            MM_RED:   o_val = $signed({1'b0, red});
            MM_GREEN: o_val = $signed({1'b0, green});
            MM_BLUE:  o_val = $signed({1'b0, blue});
            default:  o_val = $signed({1'b0, i_luma});
        endcase
    end

endmodule

[rtl/gfdmd_div.sv]
// unsigned restoring divider, one quotient bit per cycle
// depends on gfdmd_pkg
module gfdmd_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [gfdmd_pkg::DIV_NW-1:0]    i_num,
    input  logic [gfdmd_pkg::DIV_DW-1:0]    i_den,
    output logic                            o_done,
    output logic [gfdmd_pkg::DIV_NW-1:0]    o_quo
);
    import gfdmd_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   trial;

    always_comb begin
        shifted = {r_rem, r_q[DIV_NW-1]};
        trial   = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(DIV_NW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[DIV_DW]) begin
                r_rem <= trial[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIV_DW-1:0];
                r_q   <= {r_q[DIV_NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[rtl/grid_frame_difference_motion_detector.sv]
// Samples that do not end a cell are taken one per clock while the block is idle. A
// sample that ends an active cell (a frame end also ends its cell) passes from its beat
// to the next input beat through a previous-sum memory read, two parallel 33-step
// bit-serial dividers (mean difference and mean), then the result beat, held until
// taken. A sample that ends an excluded cell skips the dividers. After reset a clearing
// pass zeroes the previous-sum memory, one entry per cycle, during which no sample is
// taken; configuration writes are taken at any time. Once motion is declared the block
// swallows every sample without result until reset.
// depends on gfdmd_pkg, gfdmd_measure, gfdmd_div
module grid_frame_difference_motion_detector #(
    parameter int MAX_CELLS = gfdmd_pkg::P_MAX_CELLS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_luma,
    input  logic signed [7:0] i_chroma_u,
    input  logic signed [7:0] i_chroma_v,
    input  logic [9:0]        i_cell_index,
    input  logic [9:0]        i_cell_col,
    input  logic [9:0]        i_cell_row,
    input  logic              i_last_of_cell,
    input  logic              i_last_of_frame,
    input  logic [31:0]       i_now_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [9:0]        o_out_cell,
    output logic [7:0]        o_cell_diff,
    output logic signed [8:0] o_cell_mean,
    output logic              o_frame_done,
    output logic [15:0]       o_detected_total,
    output logic              o_triggered,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import gfdmd_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [2:0]  r_mode;
    logic [7:0]  r_thr;
    logic [31:0] r_delay;
    logic [1:0]  r_rmode;
    logic [10:0] r_cf;
    logic [10:0] r_cl;
    logic [10:0] r_rf;
    logic [10:0] r_rl;

    // accumulation and item state
    logic [31:0] r_sum;
    logic [19:0] r_cnt;
    logic [31:0] r_cur;
    logic [19:0] r_div_cnt;
    logic [AW-1:0] r_addr;
    logic        r_in_range;
    logic [9:0]  r_cell;
    logic [10:0] r_col1;
    logic [10:0] r_row1;
    logic        r_fend;
    logic [31:0] r_now;
    logic        r_active;
    logic        r_mean_neg;
    logic [15:0] r_det;
    logic        r_base;
    logic [31:0] r_start;
    logic [AW-1:0] r_clr;

    logic [31:0] r_mem [MAX_CELLS];
    logic [31:0] r_rd_data;

    // result beat
    logic [9:0]  r_o_cell;
    logic [7:0]  r_o_diff;
    logic [8:0]  r_o_mean;
    logic        r_o_fend;
    logic [15:0] r_o_det;
    logic        r_o_trig;

    logic signed [8:0] val;
    logic        accept;
    logic        cell_end;
    logic        add_ok;
    logic [31:0] sum_in;
    logic [19:0] cnt_in;
    logic [12:0] cell_ext;
    logic        clr_last;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;
    logic        div_start;
    logic        done_d;
    logic        done_m;
    logic [DIV_NW-1:0] quo_d;
    logic [DIV_NW-1:0] quo_m;
    logic [33:0] dd;
    logic [33:0] dd_mag;
    logic [32:0] cur33;
    logic [32:0] cur_mag;
    logic [10:0] c_lo;
    logic [10:0] c_hi;
    logic [10:0] row_lo;
    logic [10:0] row_hi;
    logic        in_region;
    logic        active;
    logic        delay_ok;
    logic        hit;
    logic [15:0] det_next;
    logic        trig;
    logic [8:0]  mean_val;

    gfdmd_measure u_measure (
        .i_mode (r_mode),
        .i_luma (i_luma),
        .i_u    (i_chroma_u),
        .i_v    (i_chroma_v),
        .o_val  (val)
    );

    always_comb begin
        accept   = i_valid && o_ready;
        cell_end = i_last_of_cell || i_last_of_frame;
        add_ok   = r_cnt != CNT_MAX;
        sum_in   = add_ok ? r_sum + 32'(val) : r_sum;
        cnt_in   = add_ok ? r_cnt + 20'd1 : r_cnt;
        cell_ext = 13'(i_cell_index);
        clr_last = r_clr == AW'(MAX_CELLS - 1);
    end

    // region test
    always_comb begin
        c_lo = (r_cf > r_cl) ? r_cl : r_cf;
        c_hi = (r_cf > r_cl) ? r_cf : r_cl;
        row_lo = (r_rf > r_rl) ? r_rl : r_rf;
        row_hi = (r_rf > r_rl) ? r_rf : r_rl;
        in_region = (r_col1 >= c_lo) && (r_col1 <= c_hi) &&
                    (r_row1 >= row_lo) && (r_row1 <= row_hi);
        case (r_rmode)
            RM_IN:   active = in_region;
            RM_OUT:  active = !in_region;
            default: active = 1'b1;
        endcase
        active = active && r_in_range;
    end

    // divider operands
    always_comb begin
        dd      = {{2{r_cur[31]}}, r_cur} - {{2{r_rd_data[31]}}, r_rd_data};
        dd_mag  = dd[33] ? -dd : dd;
        cur33   = {r_cur[31], r_cur};
        cur_mag = r_cur[31] ? -cur33 : cur33;
    end

    gfdmd_div u_div_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (dd_mag[DIV_NW-1:0]),
        .i_den   (r_div_cnt),
        .o_done  (done_d),
        .o_quo   (quo_d)
    );

    gfdmd_div u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (cur_mag),
        .i_den   (r_div_cnt),
        .o_done  (done_m),
        .o_quo   (quo_m)
    );

    // finishing decisions
    always_comb begin
        delay_ok = ({1'b0, r_start} + {1'b0, r_delay}) < {1'b0, r_now};
        hit      = r_active && r_base && (quo_d > DIV_NW'(r_thr)) && delay_ok;
        det_next = (hit && r_det != 16'hFFFF) ? r_det + 16'd1 : r_det;
        trig     = r_fend && r_base && (det_next != 16'd0) && delay_ok;
        mean_val = r_mean_neg ? -quo_m[8:0] : quo_m[8:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (accept && cell_end) n_state = ST_LOOK;
            ST_LOOK:  n_state = active ? ST_DIV : ST_FIN;
            ST_DIV:   if (done_d && done_m) n_state = ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT: begin
                if (i_ready) n_state = r_o_trig ? ST_STOP : ST_IDLE;
            end
            ST_STOP:  n_state = ST_STOP;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        div_start = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            ST_IDLE:  o_ready = 1'b1;
            ST_LOOK: begin
                mem_we    = r_in_range;
                mem_wdata = active ? r_cur : 32'd0;
                div_start = active;
            end
            ST_OUT:   o_valid = 1'b1;
            ST_STOP:  o_ready = 1'b1;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MM_Y;
            r_thr   <= '0;
            r_delay <= '0;
            r_rmode <= RM_ALL;
            r_cf    <= '0;
            r_cl    <= '0;
            r_rf    <= '0;
            r_rl    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MEASURE_MODE: r_mode  <= i_cfg_data[2:0];
                CFG_THRESHOLD:    r_thr   <= i_cfg_data[7:0];
                CFG_DELAY:        r_delay <= i_cfg_data;
                CFG_REGION_MODE:  r_rmode <= i_cfg_data[1:0];
                CFG_COL_FIRST:    r_cf    <= i_cfg_data[10:0];
                CFG_COL_LAST:     r_cl    <= i_cfg_data[10:0];
                CFG_ROW_FIRST:    r_rf    <= i_cfg_data[10:0];
                CFG_ROW_LAST:     r_rl    <= i_cfg_data[10:0];
                default:          r_mode  <= r_mode;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_det   <= '0;
            r_base  <= 1'b0;
            r_start <= '0;
            r_clr   <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept && r_state == ST_IDLE) begin
                if (cell_end) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= sum_in;
                    r_cnt <= cnt_in;
                end
            end
            if (r_state == ST_FIN) begin
                r_det <= det_next;
                if (r_fend && !r_base) begin
                    r_base  <= 1'b1;
                    r_start <= r_now;
                end
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (accept && r_state == ST_IDLE && cell_end) begin
            r_cur      <= sum_in;
            r_div_cnt  <= cnt_in;
            r_addr     <= cell_ext[AW-1:0];
            r_in_range <= cell_ext < 13'(MAX_CELLS);
            r_cell     <= i_cell_index;
            r_col1     <= 11'(i_cell_col) + 11'd1;
            r_row1     <= 11'(i_cell_row) + 11'd1;
            r_fend     <= i_last_of_frame;
            r_now      <= i_now_ms;
        end
        if (r_state == ST_LOOK) begin
            r_active   <= active;
            r_mean_neg <= r_cur[31];
        end
        if (r_state == ST_FIN) begin
            r_o_cell <= r_cell;
            r_o_diff <= r_active ? ((|quo_d[DIV_NW-1:8]) ? 8'd255 : quo_d[7:0]) : 8'd0;
            r_o_mean <= r_active ? mean_val : 9'd0;
            r_o_fend <= r_fend;
            r_o_det  <= det_next;
            r_o_trig <= trig;
        end
    end

    // previous-sum memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && cell_end) begin
            r_rd_data <= r_mem[cell_ext[AW-1:0]];
        end
    end

    assign o_out_cell       = r_o_cell;
    assign o_cell_diff      = r_o_diff;
    assign o_cell_mean      = $signed(r_o_mean);
    assign o_frame_done     = r_o_fend;
    assign o_detected_total = r_o_det;
    assign o_triggered      = r_o_trig;

    a_trig_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_triggered |-> o_frame_done)
        else $error("trigger on a beat that does not end the frame");

    a_trig_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_triggered |-> o_detected_total != 16'd0)
        else $error("trigger with zero detections");

    a_no_input_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> !o_ready && !o_valid && !mem_we)
        else $error("handshake or write during division");

    a_stop_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STOP |=> r_state == ST_STOP && !o_valid)
        else $error("left stopped state");

endmodule

[tb/grid_frame_difference_motion_detector_tb.sv]
// self-checking testbench for grid_frame_difference_motion_detector: directed table then
// random frames, each result beat checked against a listed result or a cycle-free motion predictor
// depends on gfdmd_pkg and the rtl of the block
module grid_frame_difference_motion_detector_tb;
    import gfdmd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 60;

    typedef struct packed {
        logic [9:0]  cell_id;
        logic [7:0]  diff;
        logic [8:0]  mean;
        logic        fdone;
        logic [15:0] total;
        logic        trig;
    } t_cell_result;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   cfg_idx;
        logic [31:0]  cfg_data;
        logic [7:0]   y;
        logic [7:0]   u;
        logic [7:0]   v;
        logic [9:0]   cell_id;
        logic [9:0]   col;
        logic [9:0]   row;
        bit           loc;
        bit           lof;
        logic [31:0]  now;
        bit           typed;
        t_cell_result want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [7:0] i_luma = '0;
    logic signed [7:0] i_chroma_u = '0;
    logic signed [7:0] i_chroma_v = '0;
    logic [9:0] i_cell_index = '0;
    logic [9:0] i_cell_col = '0;
    logic [9:0] i_cell_row = '0;
    logic i_last_of_cell = 1'b0;
    logic i_last_of_frame = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [9:0] o_out_cell;
    logic [7:0] o_cell_diff;
    logic signed [8:0] o_cell_mean;
    logic o_frame_done;
    logic [15:0] o_detected_total;
    logic o_triggered;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    grid_frame_difference_motion_detector uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // motion state mirror
    logic [31:0] prev_sums [0:1023];
    int          cell_sum;
    logic [19:0] cell_count;
    logic [15:0] motion_count;
    bit          baseline_set;
    logic [31:0] start_ms;
    bit          halted;
    logic [2:0]  measure_sel;
    logic [7:0]  diff_threshold;
    logic [31:0] delay_ms;
    logic [1:0]  region_sel;
    logic [10:0] col_first, col_last, row_first, row_last;

    t_cell_result pending_results[$];
    int errors = 0;
    int cycles = 0;
    int sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit allow_trigger = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_cell_result w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected result beat, cell", o_out_cell, -1);
            end else begin
                w = pending_results.pop_front();
                if (o_out_cell != w.cell_id) report("out_cell", o_out_cell, w.cell_id);
                if (o_cell_diff != w.diff) report("cell_diff", o_cell_diff, w.diff);
                if (o_cell_mean != w.mean)
                    report("cell_mean", o_cell_mean, $signed(w.mean));
                if (o_frame_done != w.fdone) report("frame_done", o_frame_done, w.fdone);
                if (o_detected_total != w.total)
                    report("detected_total", o_detected_total, w.total);
                if (o_triggered != w.trig) report("triggered", o_triggered, w.trig);
            end
        end
    end

    function automatic int clip_q12(int t);
        int s;
        s = t >>> 12;
        return (s < 0) ? 0 : (s > 255) ? 255 : s;
    endfunction

    function automatic int pixel_measure(int y, int u, int v);
        case (measure_sel)
            MM_U:     return u;
            MM_V:     return v;
            MM_RED:   return clip_q12(y * 4096 + v * 5743 + 2048);
            MM_GREEN: return clip_q12(y * 4096 - u * 1411 - v * 2925 + 2048);
            MM_BLUE:  return clip_q12(y * 4096 + u * 7258 + 2048);
            default:  return y;
        endcase
    endfunction

    function automatic bit delay_over(logic [31:0] now);
        return ({1'b0, start_ms} + {1'b0, delay_ms}) < {1'b0, now};
    endfunction

    task automatic predict_motion(t_row s, output bit has, output t_cell_result r);
        logic [10:0] c1, r1, clo, chi, rlo, rhi;
        bit in_region, active;
        longint cur, prv, d, m;
        has = 0;
        r = '0;
        if (halted) return;
        if (cell_count != CNT_MAX) begin
            cell_sum += pixel_measure(s.y, $signed(s.u), $signed(s.v));
            cell_count++;
        end
        if (!s.loc && !s.lof) return;
        c1 = s.col + 11'd1;
        r1 = s.row + 11'd1;
        clo = (col_first > col_last) ? col_last : col_first;
        chi = (col_first > col_last) ? col_first : col_last;
        rlo = (row_first > row_last) ? row_last : row_first;
        rhi = (row_first > row_last) ? row_first : row_last;
        in_region = c1 >= clo && c1 <= chi && r1 >= rlo && r1 <= rhi;
        active = region_sel == RM_ALL || region_sel == 2'd3 ||
                 (region_sel == RM_IN && in_region) || (region_sel == RM_OUT && !in_region);
        if (!active) begin
            prev_sums[s.cell_id] = '0;
        end else begin
            cur = cell_sum;
            prv = $signed(prev_sums[s.cell_id]);
            d = (cur - prv) / longint'(cell_count);
            m = cur / longint'(cell_count);
            if (d < 0) d = -d;
            if (baseline_set && d > diff_threshold && delay_over(s.now) && motion_count != 16'hFFFF)
                motion_count++;
            r.diff = (d > 255) ? 8'd255 : d[7:0];
            r.mean = m[8:0];
            prev_sums[s.cell_id] = cell_sum;
        end
        cell_sum = 0;
        cell_count = '0;
        if (s.lof) begin
            if (!baseline_set) begin
                baseline_set = 1;
                start_ms = s.now;
            end else if (motion_count != 0 && delay_over(s.now)) begin
                halted = 1;
                r.trig = 1;
            end
        end
        r.cell_id = s.cell_id;
        r.fdone = s.lof;
        r.total = motion_count;
        has = 1;
    endtask

    task automatic wait_settled();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MEASURE_MODE: measure_sel = data[2:0];
            CFG_THRESHOLD:    diff_threshold = data[7:0];
            CFG_DELAY:        delay_ms = data;
            CFG_REGION_MODE:  region_sel = data[1:0];
            CFG_COL_FIRST:    col_first = data[10:0];
            CFG_COL_LAST:     col_last = data[10:0];
            CFG_ROW_FIRST:    row_first = data[10:0];
            default:          row_last = data[10:0];
        endcase
    endtask

    task automatic send_pixel(t_row s);
        bit has;
        t_cell_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        // a frame end stays short of the trigger time unless triggering is wanted
        if (s.lof && baseline_set && !allow_trigger && !s.typed) s.now = start_ms;
        i_valid <= 1'b1;
        i_luma <= s.y;
        i_chroma_u <= s.u;
        i_chroma_v <= s.v;
        i_cell_index <= s.cell_id;
        i_cell_col <= s.col;
        i_cell_row <= s.row;
        i_last_of_cell <= s.loc;
        i_last_of_frame <= s.lof;
        i_now_ms <= s.now;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        predict_motion(s, has, r);
        if (has) pending_results.push_back(s.typed ? s.want : r);
        sent++;
    endtask

    function automatic t_row pix(int y, int u, int v, int cell_no, int col, int row,
                                 bit loc, bit lof, logic [31:0] now);
        t_row s;
        s = '{default: '0};
        s.y = y; s.u = u; s.v = v;
        s.cell_id = cell_no; s.col = col; s.row = row;
        s.loc = loc; s.lof = lof; s.now = now;
        return s;
    endfunction

    function automatic t_row reg_row(logic [2:0] idx, logic [31:0] data);
        t_row s;
        s = '{default: '0};
        s.is_cfg = 1;
        s.cfg_idx = idx;
        s.cfg_data = data;
        return s;
    endfunction

    function automatic t_row with_result(t_row s, int cell_no, int diff, int mean, bit fdone);
        s.typed = 1;
        s.want = '{cell_id: cell_no, diff: diff, mean: mean, fdone: fdone, total: 0, trig: 0};
        return s;
    endfunction

    function automatic t_row random_pixel();
        return pix($urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                   $urandom_range(1), $urandom_range(7) == 0, $urandom);
    endfunction

    task automatic random_frame(int ncols, int nrows);
        int base, ns;
        bit last_cell;
        t_row s;
        base = ($urandom_range(3) == 0) ? $urandom_range(1023) : 0;
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < ncols; c++) begin
                ns = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
                last_cell = (r == nrows - 1) && (c == ncols - 1);
                for (int k = 0; k < ns; k++) begin
                    if ($urandom_range(19) == 0) send_pixel(random_pixel());
                    s = random_pixel();
                    s.cell_id = (r * ncols + c + base) % 1024;
                    s.col = (c + base) % 1024;
                    s.row = (r + base) % 1024;
                    s.loc = (k == ns - 1);
                    s.lof = 0;
                    if (last_cell && k == ns - 1) begin
                        s.lof = 1;
                        s.loc = ($urandom_range(3) != 0);
                        if (!baseline_set) s.now = s.now & 32'hFFFF_FFFE;
                    end
                    if ($urandom_range(3) == 0) s.now = 32'hFFFF_FFFF;
                    send_pixel(s);
                end
            end
        end
    endtask

    task automatic random_settings(int phase);
        logic [31:0] dly;
        write_reg(CFG_MEASURE_MODE, (phase < 8) ? phase : $urandom_range(7));
        write_reg(CFG_THRESHOLD, (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 255
                                  : $urandom_range(255));
        dly = (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 32'hFFFF_FFFF : $urandom;
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_REGION_MODE, phase % 4);
        write_reg(CFG_COL_FIRST, (phase % 5 == 0) ? 1024 : $urandom_range(1024));
        write_reg(CFG_COL_LAST, (phase % 5 == 1) ? 0 : $urandom_range(1024));
        write_reg(CFG_ROW_FIRST, $urandom_range(1024));
        write_reg(CFG_ROW_LAST, (phase % 5 == 2) ? 1024 : $urandom_range(1024));
    endtask

    t_row directed[$];
    t_row s;
    int phase;

    initial begin
        for (int k = 0; k < 1024; k++) prev_sums[k] = '0;
        cell_sum = 0; cell_count = '0; motion_count = '0;
        baseline_set = 0; start_ms = '0; halted = 0;
        measure_sel = MM_Y; diff_threshold = '0; delay_ms = '0; region_sel = RM_ALL;
        col_first = '0; col_last = '0; row_first = '0; row_last = '0;

        directed.push_back(with_result(pix(255, 0, 0, 0, 0, 0, 1, 0, 0), 0, 255, 255, 0));
        directed.push_back(with_result(pix(0, 8'h80, 8'h7F, 1023, 1023, 1023, 1, 0, 0),
                                       1023, 0, 0, 0));
        directed.push_back(pix(10, 0, 0, 5, 1, 1, 0, 0, 0));
        directed.push_back(with_result(pix(20, 0, 0, 5, 1, 1, 1, 0, 0), 5, 15, 15, 0));
        directed.push_back(with_result(pix(7, 0, 0, 6, 2, 1, 0, 1, 100), 6, 7, 7, 1));
        directed.push_back(reg_row(CFG_MEASURE_MODE, MM_U));
        directed.push_back(pix(0, 8'h80, 0, 2, 2, 0, 1, 0, 32'hFFFF_FFFF));
        directed.push_back(pix(0, 8'h7F, 0, 2, 2, 0, 1, 0, 0));
        directed.push_back(reg_row(CFG_MEASURE_MODE, MM_V));
        directed.push_back(pix(0, 0, 8'h80, 3, 3, 0, 1, 0, 0));
        directed.push_back(pix(0, 0, 8'h7F, 3, 3, 0, 1, 0, 0));
        directed.push_back(reg_row(CFG_MEASURE_MODE, MM_RED));
        directed.push_back(pix(255, 0, 8'h7F, 4, 0, 1, 1, 0, 0));
        directed.push_back(pix(0, 0, 8'h80, 4, 0, 1, 1, 0, 0));
        directed.push_back(reg_row(CFG_MEASURE_MODE, MM_GREEN));
        directed.push_back(pix(128, 8'h80, 8'h80, 4, 0, 1, 1, 0, 0));
        directed.push_back(reg_row(CFG_MEASURE_MODE, MM_BLUE));
        directed.push_back(pix(200, 8'h7F, 0, 4, 0, 1, 1, 0, 0));
        directed.push_back(reg_row(CFG_MEASURE_MODE, 3'd7));
        directed.push_back(reg_row(CFG_REGION_MODE, RM_IN));
        directed.push_back(reg_row(CFG_COL_FIRST, 5));
        directed.push_back(reg_row(CFG_COL_LAST, 2));
        directed.push_back(reg_row(CFG_ROW_FIRST, 1024));
        directed.push_back(reg_row(CFG_ROW_LAST, 1));
        directed.push_back(pix(90, 0, 0, 8, 2, 0, 1, 0, 0));
        directed.push_back(pix(90, 0, 0, 9, 9, 0, 1, 0, 0));
        directed.push_back(reg_row(CFG_REGION_MODE, RM_OUT));
        directed.push_back(pix(33, 0, 0, 8, 2, 0, 1, 0, 0));
        directed.push_back(pix(33, 0, 0, 9, 9, 0, 1, 0, 0));
        directed.push_back(reg_row(CFG_REGION_MODE, 2'd3));
        directed.push_back(pix(44, 0, 0, 9, 9, 0, 1, 0, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 47;
        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                i_valid <= 1'b0;
                wait_settled();
                write_reg(directed[k].cfg_idx, directed[k].cfg_data);
            end else begin
                send_pixel(directed[k]);
            end
        end

        phase = 0;
        while (sent < 1750) begin
            if (sent > 600) begin
                send_idle_pct = 47;
                recv_idle_pct = 6;
            end
            if (sent > 1200) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            i_valid <= 1'b0;
            wait_settled();
            random_settings(phase);
            repeat ($urandom_range(2, 4)) random_frame($urandom_range(1, 4), $urandom_range(1, 3));
            phase++;
        end

        // let motion be declared, then check the block stays silent
        i_valid <= 1'b0;
        wait_settled();
        write_reg(CFG_MEASURE_MODE, MM_Y);
        write_reg(CFG_REGION_MODE, RM_ALL);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_DELAY, 0);
        allow_trigger = 1;
        for (int f = 0; f < 6 && !halted; f++) begin
            for (int c = 0; c < 3; c++) begin
                s = pix($urandom_range(255), 0, 0, c, c, 0, 1, c == 2, 32'hFFFF_FFFF);
                send_pixel(s);
            end
        end
        for (int k = 0; k < 5; k++) send_pixel(random_pixel());
        i_valid <= 1'b0;
        wait_settled();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
